>>> rtl/gcd_pkg.sv
// Package for the great-circle distance block: field widths, fixed-point
// constants, CORDIC arctangent table and small helpers. No dependencies.
package gcd_pkg;

  localparam int LAT_W  = 28;   // latitude word width
  localparam int LON_W  = 29;   // longitude word width
  localparam int RAD_W  = 16;   // radius register width
  localparam int DIST_W = 34;   // distance word width
  localparam int ANG_W  = 30;   // angle difference width, Q20 degrees
  localparam int CW     = 34;   // CORDIC datapath width
  localparam int SQW    = 63;   // square root datapath width
  localparam int SQ_STEPS = 32; // result bits of the square root

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [28:0] DEG_FULL    = 29'd377487360;  // 360 deg, Q20
  localparam logic [28:0] DEG_HALF    = 29'd188743680;  // 180 deg, Q20
  localparam logic [28:0] DEG_QUARTER = 29'd94371840;   //  90 deg, Q20
  localparam logic [31:0] RECIP45     = 32'd3054198966; // floor(2^37 / 45)
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALFPI_Q30  = 31'd1686629713;
  localparam logic [30:0] GAIN_Q30    = 31'h26DD3B6A;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic [SQW-1:0]       sq_t;

  // truncated arctangent of 2^-idx, Q30 radians
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'h3243F6A8;
      1:  v = 30'h1DAC6705;
      2:  v = 30'h0FADBAFC;
      3:  v = 30'h07F56EA6;
      4:  v = 30'h03FEAB76;
      5:  v = 30'h01FFD55B;
      6:  v = 30'h00FFFAAA;
      7:  v = 30'h007FFF55;
      8:  v = 30'h003FFFEA;
      9:  v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      24: v = 30'h0000003F;
      25: v = 30'h0000001F;
      26: v = 30'h0000000F;
      27: v = 30'h00000007;
      28: v = 30'h00000003;
      29: v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

  // haversine (1 - c) / 2 of a Q30 cosine in [-1, 1]
  function automatic logic [30:0] hav_q30(input logic signed [31:0] c);
    logic signed [32:0] diff;
    diff = $signed({2'b00, ONE_Q30}) - 33'(c);
    return diff[31:1];
  endfunction

endpackage

>>> rtl/gcd_if.sv
// Channel interfaces for the great-circle distance block.
// Depends on gcd_pkg for field widths.
interface gcd_in_if import gcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] first_latitude;
  logic signed [LON_W-1:0] first_longitude;
  logic signed [LAT_W-1:0] second_latitude;
  logic signed [LON_W-1:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_km;

  modport source (output valid, distance_km, input ready);
  modport sink (input valid, distance_km, output ready);
endinterface

>>> rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode.
// Depends on gcd_pkg for the datapath type and arctangent table.
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int IDX    = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic clk,
  input  logic en,
  input  cw_t  x_i,
  input  cw_t  y_i,
  input  cw_t  z_i,
  output cw_t  x_o,
  output cw_t  y_o,
  output cw_t  z_o
);

  localparam cw_t STEP = cw_t'(atan_q30(IDX));

  cw_t  xs, ys, x_nxt, y_nxt, z_nxt;
  cw_t  x_r, y_r, z_r;
  logic rot_pos;

  always_comb begin
    xs      = x_i >>> IDX;
    ys      = y_i >>> IDX;
    rot_pos = VECTOR ? !(y_i > 0) : (z_i >= 0);
    if (rot_pos) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - STEP;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

>>> rtl/gcd_sqrt_cell.sv
// One step of the bitwise integer square root (one result bit).
// Depends on gcd_pkg for the datapath type.
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic en,
  input  sq_t  v_i,
  input  sq_t  r_i,
  output sq_t  v_o,
  output sq_t  r_o
);

  localparam logic [SQW:0] BIT = (SQW+1)'(1) << (SQW - 1 - 2 * IDX);

  logic [SQW:0] trial;
  sq_t          v_nxt, r_nxt, v_r, r_r;

  always_comb begin
    trial = {1'b0, r_i} + BIT;
    if ({1'b0, v_i} >= trial) begin
      v_nxt = SQW'({1'b0, v_i} - trial);
      r_nxt = SQW'((r_i >> 1) + BIT);
    end else begin
      v_nxt = v_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
      r_r <= r_nxt;
    end
  end

  assign v_o = v_r;
  assign r_o = r_r;

endmodule

>>> rtl/gcd_cos.sv
// Cosine lane: angle reduction, degree to radian conversion and a row of
// rotation cells. Depends on gcd_pkg and gcd_cordic_cell.
module gcd_cos import gcd_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] deg_i,
  output logic signed [31:0]      cos_o
);

  // reduction
  logic [ANG_W-2:0] mag, red, fold;
  logic [26:0]      u_nxt;
  logic             neg_nxt;
  logic [26:0]      u_r;
  logic             neg_a_r, neg_b_r, neg_c_r, neg_d_r, neg_e_r;
  // radian conversion
  logic [36:0]      t_b_r, t_c_r, t_d_r;
  logic [50:0]      ph_r;
  logic [49:0]      pl_r;
  logic [68:0]      psum;
  logic [30:0]      q0_r;
  logic [36:0]      rem;
  cw_t              z_r;
  logic [STAGES-1:0] neg_l_r;
  // rotation chain
  cw_t              xv [STAGES+1];
  cw_t              yv [STAGES+1];
  cw_t              zv [STAGES+1];
  cw_t              xf;
  logic signed [31:0] mag_c, cos_nxt, cos_r;

  always_comb begin
    mag  = deg_i[ANG_W-1] ? (ANG_W-1)'(-deg_i) : deg_i[ANG_W-2:0];
    red  = (mag >= DEG_FULL) ? mag - DEG_FULL : mag;
    fold = (red > DEG_HALF) ? DEG_FULL - red : red;
    if (fold > DEG_QUARTER) begin
      u_nxt   = 27'(DEG_HALF - fold);
      neg_nxt = 1'b1;
    end else begin
      u_nxt   = fold[26:0];
      neg_nxt = 1'b0;
    end
  end

  assign psum = (69'(ph_r) << 18) + 69'(pl_r);
  assign rem  = t_d_r - 37'(q0_r) * 37'd45;

  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= u_nxt;
      neg_a_r <= neg_nxt;
      // t = round-half-up scaling numerator over 2^22, still to divide by 45
      t_b_r   <= 37'((59'(u_r) * 59'(PI_Q30) + 59'(DEG_QUARTER)) >> 22);
      neg_b_r <= neg_a_r;
      ph_r    <= 51'(t_b_r[36:18]) * 51'(RECIP45);
      pl_r    <= 50'(t_b_r[17:0]) * 50'(RECIP45);
      t_c_r   <= t_b_r;
      neg_c_r <= neg_b_r;
      q0_r    <= 31'(psum >> 37);
      t_d_r   <= t_c_r;
      neg_d_r <= neg_c_r;
      // quotient estimate is low by at most one
      z_r     <= cw_t'(q0_r) + ((rem >= 37'd45) ? cw_t'(1) : cw_t'(0));
      neg_e_r <= neg_d_r;
      neg_l_r <= {neg_l_r[STAGES-2:0], neg_e_r};
      cos_r   <= cos_nxt;
    end
  end

  assign xv[0] = cw_t'(GAIN_Q30);
  assign yv[0] = '0;
  assign zv[0] = z_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    gcd_cordic_cell #(.IDX(i), .VECTOR(1'b0)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (xv[i]),
      .y_i (yv[i]),
      .z_i (zv[i]),
      .x_o (xv[i+1]),
      .y_o (yv[i+1]),
      .z_o (zv[i+1])
    );
  end

  always_comb begin
    xf = xv[STAGES];
    if (xf < 0) begin
      mag_c = '0;
    end else if (xf > cw_t'(ONE_Q30)) begin
      mag_c = 32'(ONE_Q30);
    end else begin
      mag_c = 32'(xf);
    end
    cos_nxt = neg_l_r[STAGES-1] ? -mag_c : mag_c;
  end

  assign cos_o = cos_r;

endmodule

>>> rtl/great_circle_distance.sv
// Top level of the haversine great-circle distance pipeline.
// Depends on gcd_pkg, gcd_if, gcd_cos, gcd_sqrt_cell and gcd_cordic_cell.
//
// Takes one pair of points per word (latitude/longitude in Q20 degrees) and
// returns radius * central angle in Q16 kilometres. The block is a single
// stall-on-backpressure pipeline built from rows of cells: four cosine lanes
// (each CORDIC_STAGES rotation cells), two 32-cell square-root rows and a
// CORDIC_STAGES-cell vectoring row. Throughput is one word per clock while
// the output is not stalled. The whole pipeline holds while the output word
// is valid and not taken, so in_word.ready follows out_word.ready whenever
// the output register is full. The radius register (cfg_wdata on cfg_we)
// resets to 6371 km and is read at the last stage, so write it only while
// the pipeline is empty.
module great_circle_distance import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [RAD_W-1:0] cfg_wdata,
  gcd_in_if.sink           in_word,
  gcd_out_if.source        out_word
);

  localparam int LAT = 2 * CORDIC_STAGES + 43;

  logic                    en;
  logic [RAD_W-1:0]        rad_r;
  logic [LAT-1:0]          vld_r;
  logic                    out_vld_r;
  logic [DIST_W-1:0]       dist_r;

  // input stage: four angles
  logic signed [ANG_W-1:0] d_r [4];
  logic signed [31:0]      cos_w [4];

  // combine stages
  logic signed [63:0]      pf_r;
  logic [30:0]             hlat_r, hlat2_r, hlon_r;
  logic signed [31:0]      p_w;
  logic signed [63:0]      q_r;
  logic signed [33:0]      a_sum;
  logic [30:0]             a_c;
  sq_t                     va_nxt, vb_nxt;

  // square roots and arctangent
  sq_t                     sva [SQ_STEPS+1];
  sq_t                     sra_ [SQ_STEPS+1];
  sq_t                     svb [SQ_STEPS+1];
  sq_t                     srb [SQ_STEPS+1];
  cw_t                     xv [CORDIC_STAGES+1];
  cw_t                     yv [CORDIC_STAGES+1];
  cw_t                     zv [CORDIC_STAGES+1];
  cw_t                     zf;
  logic [30:0]             zc;
  logic [31:0]             c_r;

  // global advance: hold everything while a result waits
  assign en            = !out_vld_r || out_word.ready;
  assign in_word.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r <= RAD_W'(6371);
    end else if (cfg_we) begin
      rad_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LAT-2:0], in_word.valid};
      out_vld_r <= vld_r[LAT-1];
    end
  end

  // angles for cos(lat1), cos(lat2), cos(dlat), cos(dlon)
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= ANG_W'(in_word.first_latitude);
      d_r[1] <= ANG_W'(in_word.second_latitude);
      d_r[2] <= ANG_W'(in_word.second_latitude) - ANG_W'(in_word.first_latitude);
      d_r[3] <= ANG_W'(in_word.second_longitude) - ANG_W'(in_word.first_longitude);
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_cos
    gcd_cos #(.STAGES(CORDIC_STAGES)) u_cos (
      .clk   (clk),
      .en    (en),
      .deg_i (d_r[l]),
      .cos_o (cos_w[l])
    );
  end

  // a = hav(dlat) + cos1*cos2*hav(dlon), one multiply per stage
  assign p_w = 32'(pf_r >>> 30);

  always_comb begin
    a_sum = $signed({3'b000, hlat2_r}) + 34'(q_r >>> 30);
    if (a_sum < 0) begin
      a_c = '0;
    end else if (a_sum > $signed({3'b000, ONE_Q30})) begin
      a_c = ONE_Q30;
    end else begin
      a_c = a_sum[30:0];
    end
    va_nxt = SQW'(a_c) << 30;
    vb_nxt = SQW'(ONE_Q30 - a_c) << 30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf_r    <= cos_w[0] * cos_w[1];
      hlat_r  <= hav_q30(cos_w[2]);
      hlon_r  <= hav_q30(cos_w[3]);
      q_r     <= p_w * $signed({1'b0, hlon_r});
      hlat2_r <= hlat_r;
      sva[0]  <= va_nxt;
      svb[0]  <= vb_nxt;
    end
  end

  assign sra_[0] = '0;
  assign srb[0]  = '0;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    gcd_sqrt_cell #(.IDX(i)) u_sqa (
      .clk (clk),
      .en  (en),
      .v_i (sva[i]),
      .r_i (sra_[i]),
      .v_o (sva[i+1]),
      .r_o (sra_[i+1])
    );
    gcd_sqrt_cell #(.IDX(i)) u_sqb (
      .clk (clk),
      .en  (en),
      .v_i (svb[i]),
      .r_i (srb[i]),
      .v_o (svb[i+1]),
      .r_o (srb[i+1])
    );
  end

  // c / 2 = atan2(sqrt(a), sqrt(1 - a)) by vectoring
  assign xv[0] = cw_t'(srb[SQ_STEPS][30:0]);
  assign yv[0] = cw_t'(sra_[SQ_STEPS][30:0]);
  assign zv[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    gcd_cordic_cell #(.IDX(i), .VECTOR(1'b1)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (xv[i]),
      .y_i (yv[i]),
      .z_i (zv[i]),
      .x_o (xv[i+1]),
      .y_o (yv[i+1]),
      .z_o (zv[i+1])
    );
  end

  always_comb begin
    zf = zv[CORDIC_STAGES];
    if (zf < 0) begin
      zc = '0;
    end else if (zf > cw_t'(HALFPI_Q30)) begin
      zc = HALFPI_Q30;
    end else begin
      zc = zf[30:0];
    end
  end

  // distance = radius * c, rounded half up from Q30 to Q16
  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= {zc, 1'b0};
      dist_r <= DIST_W'((48'(rad_r) * 48'(c_r) + 48'd8192) >> 14);
    end
  end

  assign out_word.valid       = out_vld_r;
  assign out_word.distance_km = dist_r;

endmodule

>>> verif/great_circle_distance_tb.sv
// Testbench for great_circle_distance: directed and random point pairs,
// radius changes and backpressure. Depends on gcd_pkg, gcd_if and the RTL.
`timescale 1ns / 100ps

module great_circle_distance_tb;
  import gcd_pkg::*;

  localparam int      STAGES    = 24;
  localparam int      DRAIN     = 2 * STAGES + 44 + 20; // pipeline latency plus margin
  localparam int      LIMIT     = 400000;
  localparam int      N_RANDOM  = 436;
  localparam longint  Q30       = 64'd1073741824;
  localparam longint  PI_30     = 64'd3373259426;
  localparam longint  HALFPI_30 = 64'd1686629713;
  localparam longint  GAIN_30   = 64'h26DD3B6A;
  localparam longint  FULL_DEG  = 64'd377487360;
  localparam longint  HALF_DEG  = 64'd188743680;
  localparam longint  QTR_DEG   = 64'd94371840;
  localparam int      LAT_MAX   = 94371840;
  localparam int      LON_MAX   = 188743680;

  // truncated Q30 arctangent of 2^-i
  localparam longint ARCTAN [0:31] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
    64'h00000003, 64'h00000001, 64'h00000000, 64'h00000000};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [RAD_W-1:0] cfg_wdata = '0;

  gcd_in_if  in_word ();
  gcd_out_if out_word ();

  great_circle_distance #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_word),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  // --- model state and bookkeeping ---
  logic [RAD_W-1:0]  radius_km = 16'd6371;
  logic [DIST_W-1:0] pending_distances[$];
  int                mismatches = 0;
  int                cycle_count = 0;
  int                hold_cycles = 0;  // receiver hold-off request
  bit                sender_busy = 1'b1;  // random gaps on/off
  bit                receiver_busy = 1'b1;

  // --- predictor ---

  // Q30 cosine of a Q20 degree angle: reduce, fold to [0, 90], CORDIC rotate
  function automatic longint cos_of_deg(longint deg);
    longint r, u, x, y, z, nx, ny;
    bit     flip;
    flip = 1'b0;
    r = deg % FULL_DEG;
    if (r > HALF_DEG) r -= FULL_DEG;
    if (r < -HALF_DEG) r += FULL_DEG;
    u = (r < 0) ? -r : r;
    if (u > QTR_DEG) begin
      u = HALF_DEG - u;
      flip = 1'b1;
    end
    z = longint'((longint'(unsigned'(u)) * PI_30 + HALF_DEG / 2) / HALF_DEG);
    x = GAIN_30;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
      y = ny;
    end
    if (x < 0) x = 0;
    if (x > Q30) x = Q30;
    return flip ? -x : x;
  endfunction

  function automatic longint haversine(longint c);
    return (Q30 - c) >>> 1;
  endfunction

  // bitwise floor square root of a 64-bit value
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // vectoring CORDIC: Q30 atan2(y, x) for non-negative inputs, clamped
  function automatic longint angle_of(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ARCTAN[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ARCTAN[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > HALFPI_30) z = HALFPI_30;
    return z;
  endfunction

  function automatic logic [DIST_W-1:0] distance_of(
      logic signed [LAT_W-1:0] lat1, logic signed [LON_W-1:0] lon1,
      logic signed [LAT_W-1:0] lat2, logic signed [LON_W-1:0] lon2);
    longint          hlat, hlon, prod, a, sa, sb, c;
    longint unsigned d;
    hlat = haversine(cos_of_deg(longint'(lat2) - longint'(lat1)));
    hlon = haversine(cos_of_deg(longint'(lon2) - longint'(lon1)));
    prod = (cos_of_deg(longint'(lat1)) * cos_of_deg(longint'(lat2))) >>> 30;
    a = hlat + ((prod * hlon) >>> 30);
    if (a < 0) a = 0;
    if (a > Q30) a = Q30;
    sa = longint'(root_floor(longint'(unsigned'(a)) << 30));
    sb = longint'(root_floor(longint'(unsigned'(Q30 - a)) << 30));
    c = 2 * angle_of(sa, sb);
    d = (longint'(radius_km) * longint'(unsigned'(c)) + 64'd8192) >> 14;
    return d[DIST_W-1:0];
  endfunction

  // --- mismatch reporting ---
  task automatic report(string what, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
    mismatches++;
    $display("ERROR @%0t: %s distance_km got %0d want %0d", $time, what, got, want);
  endtask

  // --- cycle limit ---
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --- result checker: every accepted output word against the oldest prediction ---
  always @(posedge clk) begin
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_distances.size() == 0) begin
        report("unexpected word,", out_word.distance_km, '0);
      end else begin
        logic [DIST_W-1:0] want;
        want = pending_distances.pop_front();
        if (out_word.distance_km !== want) report("mismatch,", out_word.distance_km, want);
      end
    end
  end

  // --- receiver: random stalls, plus a long hold-off on request ---
  initial begin
    int stall;
    out_word.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_word.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = receiver_busy ? $urandom_range(0, 13) : 0;
        if (stall > 0) begin
          out_word.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_word.ready <= 1'b1;
      // ready is high from here, so a valid seen at an edge is a taken word
      do @(posedge clk); while (!out_word.valid && hold_cycles == 0);
    end
  end

  // --- sender: one point pair per call, valid stays high across back-to-back words ---
  task automatic send_pair(logic signed [LAT_W-1:0] lat1, logic signed [LON_W-1:0] lon1,
                           logic signed [LAT_W-1:0] lat2, logic signed [LON_W-1:0] lon2);
    int gap;
    gap = sender_busy ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.first_latitude   <= lat1;
    in_word.first_longitude  <= lon1;
    in_word.second_latitude  <= lat2;
    in_word.second_longitude <= lon2;
    in_word.valid            <= 1'b1;
    do @(posedge clk); while (!in_word.ready);
    pending_distances = {pending_distances, distance_of(lat1, lon1, lat2, lon2)};
  endtask

  task automatic go_idle();
    in_word.valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // radius write, only with the pipeline drained
  task automatic set_radius(logic [RAD_W-1:0] km);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= km;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radius_km = km;
  endtask

  // random coordinates: mostly legal ranges, sometimes any bit pattern of the field
  function automatic logic signed [LAT_W-1:0] any_lat();
    if ($urandom_range(0, 9) == 0) return LAT_W'($urandom());
    return LAT_W'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic signed [LON_W-1:0] any_lon();
    if ($urandom_range(0, 9) == 0) return LON_W'($urandom());
    return LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
  endfunction

  // --- tests ---

  // poles, date line, identical and antipodal points, out-of-range wrap
  task automatic test_directed();
    logic signed [LAT_W-1:0] lat_min, lat_max, lat_top, lat_bot;
    logic signed [LON_W-1:0] lon_min, lon_max, lon_top, lon_bot;
    lat_max = LAT_W'(LAT_MAX);
    lat_min = LAT_W'(-LAT_MAX);
    lon_max = LON_W'(LON_MAX);
    lon_min = LON_W'(-LON_MAX);
    lat_top = {1'b0, {(LAT_W-1){1'b1}}};
    lat_bot = {1'b1, {(LAT_W-1){1'b0}}};
    lon_top = {1'b0, {(LON_W-1){1'b1}}};
    lon_bot = {1'b1, {(LON_W-1){1'b0}}};
    send_pair('0, '0, '0, '0);
    send_pair(lat_max, lon_max, lat_max, lon_max);   // same point
    send_pair(lat_max, '0, lat_min, '0);             // pole to pole
    send_pair('0, '0, '0, lon_max);                  // antipodal on equator
    send_pair('0, lon_min, '0, lon_max);             // same meridian across date line
    send_pair(lat_min, lon_min, lat_max, lon_max);
    send_pair('0, '0, '0, LON_W'(1));                // smallest step
    send_pair('0, '0, LAT_W'(1), '0);
    send_pair(lat_top, lon_top, lat_bot, lon_bot);   // beyond range, wraps
    send_pair(lat_bot, lon_bot, lat_bot, lon_bot);
    send_pair(lat_top, '0, '0, lon_top);
    send_pair(28'sd47185920, 29'sd0, 28'sd47185920, 29'sd94371840);
    send_pair(-28'sd47185920, 29'sd3000000, 28'sd50000000, -29'sd120000000);
    send_pair('1, '1, '0, '0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      // long runs with no gaps on either side now and then
      if (i % 100 == 0) begin
        sender_busy   = (i % 300 != 0);
        receiver_busy = (i % 200 != 0);
      end
      if ($urandom_range(0, 7) == 0)
        send_pair(any_lat(), any_lon(), any_lat(), any_lon());
      else begin
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        lat = any_lat();
        lon = any_lon();
        // nearby or identical points exercise tiny angles
        case ($urandom_range(0, 3))
          0: send_pair(lat, lon, lat, lon);
          1: send_pair(lat, lon, lat + LAT_W'(int'($urandom_range(0, 4096)) - 2048),
                       lon + LON_W'(int'($urandom_range(0, 4096)) - 2048));
          default: send_pair(lat, lon, any_lat(), any_lon());
        endcase
      end
    end
    sender_busy   = 1'b1;
    receiver_busy = 1'b1;
  endtask

  // receiver holds off while words keep coming, so the pipeline backs up
  task automatic test_backpressure();
    hold_cycles = 400;
    sender_busy = 1'b0;
    for (int i = 0; i < 150; i++) send_pair(any_lat(), any_lon(), any_lat(), any_lon());
    sender_busy = 1'b1;
  endtask

  task automatic test_radius_sweep();
    logic [RAD_W-1:0] settings [5] = '{16'd1, 16'd65535, 16'd0, 16'd40000, 16'd6371};
    foreach (settings[k]) begin
      set_radius(settings[k]);
      send_pair(28'sd0, 29'sd0, 28'sd0, 29'sd188743680);
      send_pair(28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0);
      for (int i = 0; i < 8; i++) send_pair(any_lat(), any_lon(), any_lat(), any_lon());
    end
  endtask

  initial begin
    in_word.valid            <= 1'b0;
    in_word.first_latitude   <= '0;
    in_word.first_longitude  <= '0;
    in_word.second_latitude  <= '0;
    in_word.second_longitude <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_radius_sweep();
    set_radius(16'd65535);
    test_random(N_RANDOM / 2);
    set_radius(16'd6371);
    test_random(N_RANDOM / 2);

    go_idle();
    if (mismatches == 0 && pending_distances.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
